### sv/skt_pkg.sv
// Package for the sorted key table: field widths, status and request kind codes.
// No dependencies.
`default_nettype none
package skt_pkg;
	localparam int KeyW = 32;
	localparam int HandleW = 16;
	localparam int CountW = 7;
	localparam int StatusW = 3;
	localparam int DefDepth = 64;

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_DELETE = 2'd1,
		KIND_EXACT = 2'd2,
		KIND_NEAREST = 2'd3
	} kind_t;

	localparam logic [StatusW-1:0] ST_OK = 3'd0;
	localparam logic [StatusW-1:0] ST_DUP = 3'd1;
	localparam logic [StatusW-1:0] ST_NOREC = 3'd2;
	localparam logic [StatusW-1:0] ST_NOTFOUND = 3'd3;
	localparam logic [StatusW-1:0] ST_FULL = 3'd4;

	// Commands from the controller to the cell chain.
	typedef struct packed {
		logic capture;
		logic insert;
		logic remove;
	} skt_cmd_t;

	// Status from the cell chain, valid the cycle after capture.
	typedef struct packed {
		logic hit;
		logic empty;
		logic full;
	} skt_stat_t;
endpackage
`default_nettype wire

### sv/sorted_key_table.sv
// Top level of the sorted key table: controller plus cell chain.
// Depends on skt_pkg, skt_ctrl, skt_chain.
//
// channel   direction  handshake          fields
// request   in         start & !busy      kind part_key record_handle record_present
// result    out        done (one cycle)   status found_key found_handle entry_count
//
// A request is handled as a compare in every cell, then a decide and shift.
// The result strobe rises the cycle after the decide and shift; busy is high for one cycle.
// A new request is taken while the result is shown.
// Reset empties the table at once; no clearing pass. The receiver cannot stall.
`default_nettype none
module sorted_key_table import skt_pkg::*; #(
	parameter int DEPTH = DefDepth
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic [1:0] kind,
	input wire logic [KeyW-1:0] part_key,
	input wire logic [HandleW-1:0] record_handle,
	input wire logic record_present,
	output logic done,
	output logic [StatusW-1:0] status,
	output logic [KeyW-1:0] found_key,
	output logic [HandleW-1:0] found_handle,
	output logic [CountW-1:0] entry_count
);
	skt_cmd_t cmd;
	skt_stat_t stat;
	logic [KeyW-1:0] exact_key, near_key;
	logic [HandleW-1:0] exact_handle, near_handle;
	logic [$clog2(DEPTH+1)-1:0] count;

	skt_chain #(.DEPTH(DEPTH)) u_chain (
		.clk, .arst_n, .cmd, .part_key, .record_handle, .stat,
		.exact_key, .exact_handle, .near_key, .near_handle, .count
	);

	skt_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk, .arst_n, .start, .kind, .record_present, .busy, .cmd, .stat,
		.exact_key, .exact_handle, .near_key, .near_handle, .count,
		.done, .status, .found_key, .found_handle, .entry_count
	);
endmodule
`default_nettype wire

### sv/skt_chain.sv
// Cell chain datapath: one register cell per entry, parallel compare and shift.
// Depends on skt_pkg.
`default_nettype none
module skt_chain import skt_pkg::*; #(
	parameter int DEPTH = DefDepth
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire skt_cmd_t cmd,
	input wire logic [KeyW-1:0] part_key,
	input wire logic [HandleW-1:0] record_handle,
	output skt_stat_t stat,
	output logic [KeyW-1:0] exact_key,
	output logic [HandleW-1:0] exact_handle,
	output logic [KeyW-1:0] near_key,
	output logic [HandleW-1:0] near_handle,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	localparam int CW = $clog2(DEPTH+1);

	logic [KeyW-1:0] key_q [DEPTH];
	logic [HandleW-1:0] hnd_q [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [CW-1:0] count_q;
	logic [KeyW-1:0] req_key_q;
	logic [HandleW-1:0] req_hnd_q;
	// Per cell: entry key below request, entry key equal to request (registered).
	logic [DEPTH-1:0] lt_s1, eq_s1;
	logic [DEPTH-1:0] lt_c, eq_c;

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			lt_c[i] = vld_q[i] && (key_q[i] < part_key);
			eq_c[i] = vld_q[i] && (key_q[i] == part_key);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			lt_s1 <= lt_c;
			eq_s1 <= eq_c;
			req_key_q <= part_key;
			req_hnd_q <= record_handle;
		end
	end

	// The count register moves with the valid prefix.
	assign count = count_q;

	assign stat.hit = |eq_s1;
	assign stat.empty = !vld_q[0];
	assign stat.full = vld_q[DEPTH-1];

	// One-hot selection of the exact cell and of the last cell below the key (cell 0 if none is below).
	always_comb begin
		logic [DEPTH-1:0] last_lt;
		exact_key = '0;
		exact_handle = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (eq_s1[i]) begin
				exact_key = exact_key | key_q[i];
				exact_handle = exact_handle | hnd_q[i];
			end
		end
		for (int i = 0; i < DEPTH; i++)
			last_lt[i] = lt_s1[i] && ((i == DEPTH-1) ? 1'b1 : !lt_s1[(i+1)%DEPTH]);
		near_key = '0;
		near_handle = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (last_lt[i]) begin
				near_key = near_key | key_q[i];
				near_handle = near_handle | hnd_q[i];
			end
		end
		if (lt_s1 == '0) begin
			near_key = key_q[0];
			near_handle = hnd_q[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			count_q <= '0;
		end else if (cmd.insert) begin
			vld_q <= {vld_q[DEPTH-2:0], 1'b1};
			count_q <= count_q + CW'(1);
		end else if (cmd.remove) begin
			vld_q <= {1'b0, vld_q[DEPTH-1:1]};
			count_q <= count_q - CW'(1);
		end
	end

	// Insert: the cell at the position takes the request, cells above it take their lower neighbor;
	// delete: cells at or above the hit take their upper neighbor.
	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			if (cmd.insert && !lt_s1[i]) begin
				if (i == 0 || lt_s1[(i+DEPTH-1)%DEPTH]) begin
					key_q[i] <= req_key_q;
					hnd_q[i] <= req_hnd_q;
				end else begin
					key_q[i] <= key_q[(i+DEPTH-1)%DEPTH];
					hnd_q[i] <= hnd_q[(i+DEPTH-1)%DEPTH];
				end
			end else if (cmd.remove && !lt_s1[i] && i != DEPTH-1) begin
				key_q[i] <= key_q[(i+1)%DEPTH];
				hnd_q[i] <= hnd_q[(i+1)%DEPTH];
			end
		end
	end
endmodule
`default_nettype wire

### sv/skt_ctrl.sv
// Controller: accepts a request, decides its outcome and drives the result.
// Depends on skt_pkg.
`default_nettype none
module skt_ctrl import skt_pkg::*; #(
	parameter int DEPTH = DefDepth
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [1:0] kind,
	input wire logic record_present,
	output logic busy,
	output skt_cmd_t cmd,
	input wire skt_stat_t stat,
	input wire logic [KeyW-1:0] exact_key,
	input wire logic [HandleW-1:0] exact_handle,
	input wire logic [KeyW-1:0] near_key,
	input wire logic [HandleW-1:0] near_handle,
	input wire logic [$clog2(DEPTH+1)-1:0] count,
	output logic done,
	output logic [StatusW-1:0] status,
	output logic [KeyW-1:0] found_key,
	output logic [HandleW-1:0] found_handle,
	output logic [CountW-1:0] entry_count
);
	localparam int CW = $clog2(DEPTH+1);

	typedef enum logic {S_IDLE, S_EVAL} state_t;
	state_t state_q;
	kind_t kind_q;
	logic pres_q;
	logic accept;
	logic do_ins, do_del;
	logic [StatusW-1:0] st_c;
	logic [KeyW-1:0] fk_c;
	logic [HandleW-1:0] fh_c;
	logic [CW-1:0] cnt_after;

	assign accept = start && !busy;
	assign busy = (state_q == S_EVAL);

	always_comb begin
		st_c = ST_OK;
		fk_c = '0;
		fh_c = '0;
		do_ins = 1'b0;
		do_del = 1'b0;
		unique case (kind_q)
			KIND_INSERT: begin
				if (!pres_q) st_c = ST_NOREC;
				else if (stat.hit) st_c = ST_DUP;
				else if (stat.full) st_c = ST_FULL;
				else do_ins = 1'b1;
			end
			KIND_DELETE: begin
				if (!stat.hit) st_c = ST_NOTFOUND;
				else do_del = 1'b1;
			end
			KIND_EXACT: begin
				if (stat.hit) begin
					fk_c = exact_key;
					fh_c = exact_handle;
				end else st_c = ST_NOTFOUND;
			end
			KIND_NEAREST: begin
				if (stat.empty) st_c = ST_NOTFOUND;
				else if (stat.hit) begin
					fk_c = exact_key;
					fh_c = exact_handle;
				end else begin
					fk_c = near_key;
					fh_c = near_handle;
				end
			end
			default: st_c = ST_OK;
		endcase
		cnt_after = count + CW'(do_ins) - CW'(do_del);
	end

	assign cmd.capture = accept;
	assign cmd.insert = busy && do_ins;
	assign cmd.remove = busy && do_del;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: if (accept) state_q <= S_EVAL;
				S_EVAL: begin
					state_q <= S_IDLE;
					done <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind_t'(kind);
			pres_q <= record_present;
		end
		if (busy) begin
			status <= st_c;
			found_key <= fk_c;
			found_handle <= fh_c;
			entry_count <= CountW'(cnt_after);
		end
	end
endmodule
`default_nettype wire

### sv/skt_checker.sv
// Port-level checker for the sorted key table, bound to the top level.
// Depends on skt_pkg.
`default_nettype none
module skt_checker import skt_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire logic [StatusW-1:0] status
);
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("busy not raised");
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> ##1 done) else $error("missing result");
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("unrequested result");
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status <= ST_FULL)) else $error("bad status");
	a_busy_short: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy) else $error("busy too long");
endmodule

bind sorted_key_table skt_checker u_skt_checker (
	.clk, .arst_n, .start, .busy, .done, .status
);
`default_nettype wire
